// ----- rtl/sbmq_pkg.sv -----
// shared types and codes for the shared-buffer multi-queue unit
package sbmq_pkg;

  localparam int QNUM_W   = 7;
  localparam int QIDX_W   = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADQ  = 2'd3;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_BAD = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [QIDX_W-1:0]          qidx;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

// ----- rtl/sbmq_if.sv -----
// request and response channel interfaces
interface sbmq_req_if import sbmq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [QNUM_W-1:0]          queue_number;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, req_type, queue_number, push_value, input ready);
  modport sink   (input valid, req_type, queue_number, push_value, output ready);
endinterface

interface sbmq_rsp_if import sbmq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  pop_value;

  modport source (output valid, status, pop_value, input ready);
  modport sink   (input valid, status, pop_value, output ready);
endinterface

// ----- rtl/sbmq_ram.sv -----
// generic single-port-write ram with registered read
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/sbmq_front.sv -----
// request front end: range check, classification and a two-entry command queue
module sbmq_front import sbmq_pkg::*; #(
  parameter int NUM_QUEUES = 4
) (
  input  logic       clk,
  input  logic       rst,
  sbmq_req_if.sink   req,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);
  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  cmd_t       cls;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rp];

  always_comb begin
    cls.value = req.push_value;
    cls.qidx  = QIDX_W'(req.queue_number - QNUM_W'(1));
    if (req.queue_number == '0 || req.queue_number > QNUM_W'(NUM_QUEUES)) begin
      cls.kind = CMD_BAD;
    end else if (req.req_type == REQ_DEQ) begin
      cls.kind = CMD_DEQ;
    end else begin
      cls.kind = CMD_ENQ;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- rtl/sbmq_back.sv -----
// command engine: linked slot store, free list, queue heads and tails, result register
module sbmq_back import sbmq_pkg::*; #(
  parameter int NUM_QUEUES = 4,
  parameter int CAPACITY   = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  sbmq_rsp_if.source rsp
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DEQ  = 3'b100
  } state_t;

  state_t                state, state_next;
  cmd_t                  cur;
  logic [PW-1:0]         free_head, free_head_next;
  logic [PW-1:0]         fresh, fresh_next;
  logic [NUM_QUEUES-1:0] head_valid;
  logic                  hv_set, hv_clr;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_free;

  logic                  finish;
  logic [STATUS_W-1:0]   res_status;
  logic [VALUE_W-1:0]    res_value;
  logic                  rd_en, rd2_en;
  logic [QW-1:0]         q;
  logic                  slot_free;
  logic [AW-1:0]         s;

  // ram ports
  logic                  data_we;
  logic [VALUE_W-1:0]    data_rd;
  logic                  link_we;
  logic [AW-1:0]         link_waddr, link_raddr;
  logic [PW-1:0]         link_wdata, link_rd;
  logic                  head_we;
  logic [AW-1:0]         head_wdata, head_rd;
  logic                  tail_we;
  logic [AW-1:0]         tail_rd;

  assign q         = cur.qidx[QW-1:0];
  assign s         = free_head[AW-1:0];
  assign slot_free = (free_head != PW'(CAPACITY));
  assign out_free  = !out_valid || rsp.ready;
  // link read: free-list head at issue, dequeued head slot afterwards
  assign link_raddr = (state == S_IDLE) ? free_head[AW-1:0] : head_rd;

  always_comb begin
    state_next     = state;
    cmd_pop        = 1'b0;
    rd_en          = 1'b0;
    rd2_en         = 1'b0;
    finish         = 1'b0;
    res_status     = ST_DONE;
    res_value      = '1;
    data_we        = 1'b0;
    link_we        = 1'b0;
    link_waddr     = tail_rd;
    link_wdata     = PW'(s);
    head_we        = 1'b0;
    head_wdata     = s;
    tail_we        = 1'b0;
    hv_set         = 1'b0;
    hv_clr         = 1'b0;
    free_head_next = free_head;
    fresh_next     = fresh;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          rd_en      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur.kind)
          CMD_ENQ: begin
            finish = out_free;
            if (!slot_free) begin
              res_status = ST_FULL;
            end else if (out_free) begin
              data_we = 1'b1;
              tail_we = 1'b1;
              if (head_valid[q]) begin
                link_we = 1'b1;
              end else begin
                head_we = 1'b1;
                hv_set  = 1'b1;
              end
              // slots at or above the fresh mark were never used and link to the next
              if (free_head == fresh) begin
                free_head_next = free_head + PW'(1);
                fresh_next     = fresh + PW'(1);
              end else begin
                free_head_next = link_rd;
              end
            end
          end
          CMD_DEQ: begin
            if (!head_valid[q]) begin
              res_status = ST_EMPTY;
              finish     = out_free;
            end else begin
              rd2_en     = 1'b1;
              state_next = S_DEQ;
            end
          end
          default: begin
            res_status = ST_BADQ;
            finish     = out_free;
          end
        endcase
      end
      S_DEQ: begin
        res_value = data_rd;
        finish    = out_free;
        if (out_free) begin
          link_we        = 1'b1;
          link_waddr     = head_rd;
          link_wdata     = free_head;
          free_head_next = PW'(head_rd);
          // the tail was the only entry left
          if (head_rd == tail_rd) begin
            hv_clr = 1'b1;
          end else begin
            head_we    = 1'b1;
            head_wdata = link_rd[AW-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (finish) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      fresh      <= '0;
      head_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      if (hv_set) begin
        head_valid[q] <= 1'b1;
      end else if (hv_clr) begin
        head_valid[q] <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.pop_value = out_value;

  sbmq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (s),
    .wdata (cur.value),
    .re    (rd2_en),
    .raddr (head_rd),
    .rdata (data_rd)
  );

  sbmq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en || rd2_en),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  sbmq_ram #(.WIDTH(AW), .DEPTH(NUM_QUEUES)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (q),
    .wdata (head_wdata),
    .re    (rd_en),
    .raddr (cmd.qidx[QW-1:0]),
    .rdata (head_rd)
  );

  sbmq_ram #(.WIDTH(AW), .DEPTH(NUM_QUEUES)) u_tail (
    .clk   (clk),
    .we    (tail_we),
    .waddr (q),
    .wdata (s),
    .re    (rd_en),
    .raddr (cmd.qidx[QW-1:0]),
    .rdata (tail_rd)
  );

`ifndef SYNTH
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= PW'(CAPACITY) && free_head <= fresh)
    else $error("free list head beyond fresh mark");

  a_fresh_step: assert property (@(posedge clk) disable iff (rst)
    fresh != $past(fresh) |-> $past(state == S_EXEC && cur.kind == CMD_ENQ))
    else $error("fresh mark moved outside an enqueue");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC || state == S_DEQ))
    else $error("result produced outside an execute step");

  a_one_pop: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> !cmd_pop)
    else $error("two commands taken in consecutive cycles");
`endif
endmodule

// ----- rtl/shared_buffer_multi_queue_unit.sv -----
// engine steps: an idle state takes a command and reads the queue head and tail (and the free-list link),
// an execute state finishes enqueues and bad numbers, and dequeues add a state that reads the slot data;
// each step that loads the result register waits while it is still full, and no new command is taken until then
// the two-entry command queue keeps taking requests while a result waits, until both entries are full
// reset: synchronous, all queues empty, every slot free in ascending order,
// no clearing pass (untouched slots are tracked by a fresh-slot mark)
module shared_buffer_multi_queue_unit import sbmq_pkg::*; #(
  parameter int NUM_QUEUES = 4,
  parameter int CAPACITY   = 256
) (
  input  logic       clk,
  input  logic       rst,
  sbmq_req_if.sink   req,
  sbmq_rsp_if.source rsp
);
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sbmq_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sbmq_back #(.NUM_QUEUES(NUM_QUEUES), .CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );
endmodule

// ----- tb/sv/shared_buffer_multi_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for the shared-buffer multi-queue unit: random and corner-case traffic, scoreboarded
module shared_buffer_multi_queue_unit_tb;
  import sbmq_pkg::*;

  localparam int NUM_QUEUES = 4;
  localparam int CAPACITY   = 256;
  localparam int LINK_W     = $clog2(CAPACITY + 1);
  localparam int NULL_SLOT  = CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] pop_value;
  } sbmq_result_t;

  logic clk;
  logic rst;

  sbmq_req_if req_ch ();
  sbmq_rsp_if rsp_ch ();

  shared_buffer_multi_queue_unit #(
    .NUM_QUEUES(NUM_QUEUES),
    .CAPACITY  (CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the linked store
  logic [VALUE_W-1:0] slot_val  [CAPACITY];
  logic [LINK_W-1:0]  slot_next [CAPACITY];
  logic [LINK_W-1:0]  q_head    [NUM_QUEUES];
  logic [LINK_W-1:0]  q_tail    [NUM_QUEUES];
  logic [LINK_W-1:0]  free_slot;
  int                 slots_used;

  sbmq_result_t pending_results[$];

  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  status_hits[4];
  int  pops_done;
  int  cycles;
  int  idle_pct;
  int  stall_pct;
  bit  calm;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("shared_buffer_multi_queue_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // next state and result of one request, applied at acceptance
  function automatic void predict_request(input logic op, input logic [QNUM_W-1:0] qn,
                                          input logic [VALUE_W-1:0] v,
                                          output sbmq_result_t r);
    int q;
    logic [LINK_W-1:0] s;
    r.status    = ST_DONE;
    r.pop_value = '1;
    if (qn == 0 || qn > NUM_QUEUES) begin
      r.status = ST_BADQ;
    end else begin
      q = qn - 1;
      if (op == REQ_ENQ) begin
        s = free_slot;
        if (s == NULL_SLOT) begin
          r.status = ST_FULL;
        end else begin
          slot_val[s] = v;
          free_slot = slot_next[s];
          if (q_head[q] == NULL_SLOT) q_head[q] = s;
          else slot_next[q_tail[q]] = s;
          slot_next[s] = LINK_W'(NULL_SLOT);
          q_tail[q] = s;
          slots_used++;
        end
      end else begin
        s = q_head[q];
        if (s == NULL_SLOT) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = slot_val[s];
          q_head[q] = slot_next[s];
          slot_next[s] = free_slot;
          free_slot = s;
          slots_used--;
          pops_done++;
        end
      end
    end
    status_hits[r.status]++;
  endfunction

  task automatic send_req(input logic op, input logic [QNUM_W-1:0] qn,
                          input logic [VALUE_W-1:0] v);
    sbmq_result_t r;
    @(negedge clk);
    if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.req_type     = op;
    req_ch.queue_number = qn;
    req_ch.push_value   = v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(op, qn, v, r);
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [QNUM_W-1:0] pick_qnum(input int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) return QNUM_W'($urandom_range(0, 127));
    return QNUM_W'($urandom_range(1, NUM_QUEUES));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // response check
  always @(posedge clk) begin : chk
    sbmq_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(rsp_ch.status), 32'(rsp_ch.pop_value));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.pop_value !== want.pop_value)
          report_mismatch("pop_value", rsp_ch.pop_value, want.pop_value);
      end
    end
  end

  // sink side back-pressure in bursts
  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm || stall_pct == 0) begin
        rsp_ch.ready = 1'b1;
        stall_left = 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  task automatic test_corner_cases();
    int i;
    idle_pct  = 15;
    stall_pct = 15;
    for (i = 1; i <= NUM_QUEUES; i++) send_req(REQ_DEQ, QNUM_W'(i), $urandom());
    // bad numbers, including the all-ones number
    send_req(REQ_ENQ, 7'd0, 32'h1234_5678);
    send_req(REQ_DEQ, 7'd0, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, QNUM_W'(NUM_QUEUES + 1), 32'h0);
    send_req(REQ_DEQ, 7'd64, 32'h0);
    send_req(REQ_ENQ, 7'd127, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, 7'd1, 32'h8000_0000);
    send_req(REQ_ENQ, 7'd1, 32'h7FFF_FFFF);
    send_req(REQ_ENQ, 7'd2, 32'h0000_0000);
    send_req(REQ_ENQ, 7'd3, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, 7'd4, 32'h5555_5555);
    send_req(REQ_ENQ, 7'd4, 32'hAAAA_AAAA);
    send_req(REQ_DEQ, 7'd1, 32'hDEAD_BEEF);
    send_req(REQ_DEQ, 7'd1, 32'h0);
    send_req(REQ_DEQ, 7'd1, 32'h0);
    send_req(REQ_DEQ, 7'd2, 32'h0);
    send_req(REQ_DEQ, 7'd3, 32'h0);
    send_req(REQ_DEQ, 7'd4, 32'h0);
    send_req(REQ_DEQ, 7'd4, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    idle_pct  = 20;
    stall_pct = 20;
    // every slot taken, then a few more into a full store
    repeat (CAPACITY + 6) send_req(REQ_ENQ, pick_qnum(0), pick_value());
    wait_drained();
    while (slots_used != 0)
      send_req(REQ_DEQ, QNUM_W'($urandom_range(1, NUM_QUEUES)), $urandom());
  endtask

  task automatic test_random_mix(input int n, input int enq_pct, input int bad_pct,
                                 input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(0, 99) < enq_pct) send_req(REQ_ENQ, pick_qnum(bad_pct), pick_value());
      else send_req(REQ_DEQ, pick_qnum(bad_pct), $urandom());
    end
  endtask

  initial begin : main
    int i;
    rst = 1'b1;
    calm = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    pops_done = 0;
    cycles = 0;
    status_hits = '{default: 0};
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ENQ;
    req_ch.queue_number = '0;
    req_ch.push_value = '0;
    for (i = 0; i < CAPACITY; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = LINK_W'(i + 1);
    end
    for (i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = LINK_W'(NULL_SLOT);
      q_tail[i] = '0;
    end
    free_slot = '0;
    slots_used = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_cases();
    wait_drained();
    test_fill_and_drain();
    test_random_mix(400, 70, 5, 25, 25);
    test_random_mix(300, 80, 5, 10, 40);
    wait_drained();
    test_random_mix(300, 30, 5, 0, 0);
    // back-to-back traffic with an always-ready sink
    calm = 1'b1;
    test_random_mix(250, 50, 5, 0, 0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d transactions, checked %0d results in %0d cycles", items_sent,
             results_seen, cycles);
    $display("done %0d (pops %0d), full %0d, empty %0d, bad queue %0d", status_hits[ST_DONE],
             pops_done, status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_BADQ]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("shared_buffer_multi_queue_unit_tb: PASS");
    end else begin
      $display("shared_buffer_multi_queue_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sbmq_pkg.sv
rtl/sbmq_if.sv
rtl/sbmq_ram.sv
rtl/sbmq_front.sv
rtl/sbmq_back.sv
rtl/shared_buffer_multi_queue_unit.sv
tb/sv/shared_buffer_multi_queue_unit_tb.sv
